[rtl/core/fixed_capacity_array_list_core_assert.svh]
// Assertion macros used by the checker module of this block.
`ifndef FIXED_CAPACITY_ARRAY_LIST_CORE_ASSERT_SVH
`define FIXED_CAPACITY_ARRAY_LIST_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FCAL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FCAL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fcal_pkg.sv]
package fcal_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W = 5;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_SORTED = 3'd1;
   localparam logic [OP_W-1:0] OP_LOCATE = 3'd2;
   localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] STS_MISSING = 2'd3;

   typedef struct packed {
      logic                       valid;
      logic [STATUS_W-1:0]        status;
      logic signed [INDEX_W-1:0]  found_index;
      logic signed [DATA_W-1:0]   read_value;
      logic [COUNT_W-1:0]         entry_count;
   } rsp_type;

endpackage

[rtl/core/fcal_mem.sv]
module fcal_mem
   import fcal_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/fcal_seq.sv]
module fcal_seq
   import fcal_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_data,
   input  logic [POS_W-1:0]         req_pos,
   input  logic                     out_free,
   output rsp_type                  result,
   output logic                     mem_wr_en,
   output logic [ADDR_W-1:0]        mem_wr_addr,
   output logic signed [DATA_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0]        mem_rd_addr,
   input  logic signed [DATA_W-1:0] mem_rd_data
);

   localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_LOAD   = 7'b0000100,
      S_SHIFT  = 7'b0001000,
      S_PLACE  = 7'b0010000,
      S_RDWAIT = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic [ADDR_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [ADDR_W-1:0]        ins_pos_ff, ins_pos_in;
   logic [ADDR_W-1:0]        dst_ff, dst_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [INDEX_W-1:0] found_ff, found_in;
   logic signed [DATA_W-1:0] readv_ff, readv_in;

   logic [WIDE_W-1:0] pos_wide;
   logic [WIDE_W-1:0] cnt_wide;
   logic              is_full;
   logic              hit;
   logic              last_entry;

   assign pos_wide = WIDE_W'(req_pos);
   assign cnt_wide = WIDE_W'(count_ff);
   assign is_full = (count_ff == CAP_CNT);
   assign req_ready = (state_ff == S_IDLE) && !reset;

   // A sorted insert stops at the first entry that is not less than the value.
   assign hit = (op_ff == OP_LOCATE) ? (mem_rd_data == data_ff) : !(mem_rd_data < data_ff);
   assign last_entry = (CNT_W'(cmp_idx_ff) == CNT_W'(count_ff - 1'b1));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in = op_ff;
      data_in = data_ff;
      cmp_idx_in = cmp_idx_ff;
      ins_pos_in = ins_pos_ff;
      dst_in = dst_ff;
      status_in = status_ff;
      found_in = found_ff;
      readv_in = readv_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = dst_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = '0;
      result.valid = 1'b0;
      result.status = status_ff;
      result.found_index = found_ff;
      result.read_value = readv_ff;
      result.entry_count = COUNT_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               data_in = req_data;
               status_in = STS_OK;
               found_in = '1;
               readv_in = '1;
               state_in = S_DONE;
               unique case (req_op)
                  OP_INSERT: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else if (pos_wide > cnt_wide) begin
                        status_in = STS_BADPOS;
                     end else begin
                        ins_pos_in = ADDR_W'(req_pos);
                        state_in = S_LOAD;
                     end
                  end
                  OP_SORTED: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else if (count_ff == '0) begin
                        ins_pos_in = '0;
                        state_in = S_LOAD;
                     end else begin
                        cmp_idx_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_LOCATE: begin
                     if (count_ff == '0) begin
                        status_in = STS_MISSING;
                     end else begin
                        cmp_idx_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_RETRIEVE: begin
                     if (pos_wide >= cnt_wide) begin
                        status_in = STS_BADPOS;
                     end else begin
                        mem_rd_addr = ADDR_W'(req_pos);
                        state_in = S_RDWAIT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Read data here belongs to cmp_idx_ff; the next address is read ahead.
            if (hit) begin
               if (op_ff == OP_LOCATE) begin
                  found_in = INDEX_W'(cmp_idx_ff);
                  state_in = S_DONE;
               end else begin
                  ins_pos_in = cmp_idx_ff;
                  state_in = S_LOAD;
               end
            end else if (last_entry) begin
               if (op_ff == OP_LOCATE) begin
                  status_in = STS_MISSING;
                  state_in = S_DONE;
               end else begin
                  ins_pos_in = ADDR_W'(count_ff);
                  state_in = S_LOAD;
               end
            end else begin
               mem_rd_addr = ADDR_W'(cmp_idx_ff + 1'b1);
               cmp_idx_in = ADDR_W'(cmp_idx_ff + 1'b1);
            end
         end
         S_LOAD: begin
            if (CNT_W'(ins_pos_ff) == count_ff) begin
               state_in = S_PLACE;
            end else begin
               mem_rd_addr = ADDR_W'(count_ff - 1'b1);
               dst_in = ADDR_W'(count_ff);
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // Each entry moves up by one, walking down from the top of the list.
            mem_wr_en = 1'b1;
            mem_wr_addr = dst_ff;
            mem_wr_data = mem_rd_data;
            if (ADDR_W'(dst_ff - 1'b1) == ins_pos_ff) begin
               state_in = S_PLACE;
            end else begin
               mem_rd_addr = ADDR_W'(dst_ff - 2'd2);
               dst_in = ADDR_W'(dst_ff - 1'b1);
            end
         end
         S_PLACE: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = ins_pos_ff;
            mem_wr_data = data_ff;
            count_in = CNT_W'(count_ff + 1'b1);
            state_in = S_DONE;
         end
         S_RDWAIT: begin
            readv_in = mem_rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      data_ff <= data_in;
      cmp_idx_ff <= cmp_idx_in;
      ins_pos_ff <= ins_pos_in;
      dst_ff <= dst_in;
      status_ff <= status_in;
      found_ff <= found_in;
      readv_ff <= readv_in;
   end

endmodule

[rtl/core/fixed_capacity_array_list_core.sv]
// Clear and error cases go straight to the result; retrieve reads one entry; locate scans
// from entry 0; insert at p moves entries p and up, then writes; sorted insert scans first.
// One transaction is worked on at a time; the entry memory's single read and write port
// sets the pace of the scan and of the shift. The next transaction is taken as soon as the
// previous result sits in the output register. Reset clears the entry count and the output
// valid; the entry memory is not cleared, and no clearing pass is needed.
module fixed_capacity_array_list_core
   import fcal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // data[31:0], position[36:32], zero pad
   input  logic [OP_W-1:0]        req_tuser,  // operation[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // found_index[4:0], read_value[36:5],
                                              // entry_count[41:37], zero pad
   output logic [STATUS_W-1:0]    rsp_tuser   // status[1:0]
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   rsp_type                  result;
   logic                     out_free;
   logic                     mem_wr_en;
   logic [ADDR_W-1:0]        mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]        mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [INDEX_W-1:0] rsp_found_ff;
   logic signed [DATA_W-1:0]  rsp_readv_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   fcal_seq #(
      .CAPACITY(CAPACITY)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_op(req_tuser),
      .req_data(req_tdata[DATA_W-1:0]),
      .req_pos(req_tdata[DATA_W+POS_W-1:DATA_W]),
      .out_free(out_free),
      .result(result),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   fcal_mem #(
      .DEPTH(CAPACITY)
   ) u_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_found_ff <= result.found_index;
         rsp_readv_ff <= result.read_value;
         rsp_count_ff <= result.entry_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {
      (RSP_TDATA_W - COUNT_W - DATA_W - INDEX_W)'(0),
      rsp_count_ff,
      rsp_readv_ff,
      rsp_found_ff
   };

endmodule

[rtl/core/fcal_chk.sv]
`include "fixed_capacity_array_list_core_assert.svh"

module fcal_chk
   import fcal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [OP_W-1:0]        req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // A stalled result keeps its contents.
   `FCAL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // The count never goes past the capacity.
   `FCAL_ASSERT_NOW(a_count_cap, clock, reset, rsp_tvalid, (CAPACITY > 31) || (rsp_tdata[41:37] <= 5'(CAPACITY)), "entry count above capacity")

   // A full report only comes from a list that is full.
   `FCAL_ASSERT_NOW(a_full_count, clock, reset, rsp_tvalid && (rsp_tuser == STS_FULL), rsp_tdata[41:37] == 5'(CAPACITY), "full status with room left")

   // Every error result carries the not-found index and the error read value.
   `FCAL_ASSERT_NOW(a_err_fields, clock, reset, rsp_tvalid && (rsp_tuser != STS_OK), (rsp_tdata[4:0] == 5'h1f) && (rsp_tdata[36:5] == 32'hffff_ffff), "error result with live fields")

endmodule

bind fixed_capacity_array_list_core fcal_chk #(.CAPACITY(CAPACITY)) u_fcal_chk (.*);
